### rtl/igs_pkg.sv
// Shared types and constants for the idle gap statistics block.
package igs_pkg;

	localparam int PENDING_WIDTH = 16;

	typedef enum logic [1:0] {
		CMD_ISSUE    = 2'd0,
		CMD_COMPLETE = 2'd1,
		CMD_REQUEUE  = 2'd2
	} cmd_t;

	typedef struct packed {
		logic [PENDING_WIDTH-1:0] pending_count;
		logic [63:0]              last_complete_time;
		logic                     last_complete_valid;
		logic [63:0]              pending_gap;
		logic                     pending_gap_valid;
		logic [63:0]              sum_of_gaps;
		logic [63:0]              least_gap;
		logic [63:0]              greatest_gap;
		logic [31:0]              number_of_gaps;
	} stats_state_t;

	typedef struct packed {
		logic        gap_closed;
		logic [63:0] gap_value;
		logic [63:0] gap_total;
		logic [63:0] gap_min;
		logic [63:0] gap_max;
		logic [31:0] gap_count;
		logic [15:0] pending_requests;
	} stats_result_t;

endpackage

### rtl/igs_update.sv
// Next-state and result logic for one storage event.
module igs_update (
	input  igs_pkg::stats_state_t  cur,
	input  logic [1:0]             cmd,
	input  logic [63:0]            time_req,
	output igs_pkg::stats_state_t  nxt,
	output igs_pkg::stats_result_t res
);
	import igs_pkg::*;

	localparam logic [PENDING_WIDTH-1:0] COUNT_MAX = '1;

	logic        closed;
	logic [63:0] value;
	logic [31:0] count_ext;

	always_comb begin
		nxt    = cur;
		closed = 1'b0;
		value  = '0;
		unique case (cmd)
			CMD_ISSUE: begin
				if (cur.pending_count == '0 && cur.last_complete_valid) begin
					nxt.pending_gap       = time_req - cur.last_complete_time;
					nxt.pending_gap_valid = 1'b1;
				end
				if (cur.pending_count != COUNT_MAX) begin
					nxt.pending_count = cur.pending_count + 1'b1;
				end
			end
			CMD_COMPLETE: begin
				if (cur.pending_count != '0) begin
					nxt.pending_count = cur.pending_count - 1'b1;
					// The last outstanding request finished: the device goes idle.
					if (cur.pending_count == PENDING_WIDTH'(1)) begin
						nxt.last_complete_time  = time_req;
						nxt.last_complete_valid = 1'b1;
						if (cur.pending_gap_valid) begin
							closed                = 1'b1;
							value                 = cur.pending_gap;
							nxt.sum_of_gaps       = cur.sum_of_gaps + cur.pending_gap;
							if (cur.pending_gap < cur.least_gap) begin
								nxt.least_gap = cur.pending_gap;
							end
							if (cur.pending_gap > cur.greatest_gap) begin
								nxt.greatest_gap = cur.pending_gap;
							end
							nxt.number_of_gaps    = cur.number_of_gaps + 32'd1;
							nxt.pending_gap_valid = 1'b0;
						end
					end
				end
			end
			CMD_REQUEUE: begin
				if (cur.pending_count != '0) begin
					nxt.pending_count = cur.pending_count - 1'b1;
					if (cur.pending_count == PENDING_WIDTH'(1)) begin
						nxt.pending_gap_valid = 1'b0;
					end
				end
			end
			default: begin
			end
		endcase
	end

	assign count_ext = 32'(nxt.pending_count);

	always_comb begin
		res.gap_closed       = closed;
		res.gap_value        = value;
		res.gap_total        = nxt.sum_of_gaps;
		res.gap_min          = nxt.least_gap;
		res.gap_max          = nxt.greatest_gap;
		res.gap_count        = nxt.number_of_gaps;
		res.pending_requests = count_ext[15:0];
	end

endmodule

### rtl/idle_gap_statistics_core.sv
// Top level of the idle gap statistics block: input register, update, result register.
//
//   channel | valid     | stall     | payload
//   --------+-----------+-----------+-------------------------------------------
//   req     | req_valid | req_stall | cmd, time_req
//   res     | res_valid | res_stall | gap_closed, gap_value, gap_total, gap_min,
//           |           |           | gap_max, gap_count, pending_requests
//
// Each event passes through the input register, the single update step and the result
// register, and one event can be taken every cycle while the result side does not stall.
// Reset clears the statistics, the outstanding count and both valid flags.
// A stall on the result side holds a valid result in the result register and, when the input
// register is also full, stalls the request side in the same cycle.
module idle_gap_statistics_core (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        req_valid,
	output logic        req_stall,
	input  logic [1:0]  cmd,
	input  logic [63:0] time_req,
	output logic        res_valid,
	input  logic        res_stall,
	output logic        gap_closed,
	output logic [63:0] gap_value,
	output logic [63:0] gap_total,
	output logic [63:0] gap_min,
	output logic [63:0] gap_max,
	output logic [31:0] gap_count,
	output logic [15:0] pending_requests
);
	import igs_pkg::*;

	logic          valid_s1;
	logic [1:0]    cmd_s1;
	logic [63:0]   time_s1;
	logic          valid_s2;
	stats_result_t res_s2;
	stats_state_t  state_q;
	stats_state_t  state_next;
	stats_result_t res_next;
	logic          advance;
	logic          req_take;

	assign advance   = valid_s1 && (!valid_s2 || !res_stall);
	assign req_stall = valid_s1 && valid_s2 && res_stall;
	assign req_take  = req_valid && !req_stall;

	igs_update u_update (
		.cur      (state_q),
		.cmd      (cmd_s1),
		.time_req (time_s1),
		.nxt      (state_next),
		.res      (res_next)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			state_q  <= '{pending_count: '0, last_complete_time: '0,
				last_complete_valid: 1'b0, pending_gap: '0,
				pending_gap_valid: 1'b0, sum_of_gaps: '0, least_gap: '1,
				greatest_gap: '0, number_of_gaps: '0};
		end else begin
			if (req_take) begin
				valid_s1 <= 1'b1;
			end else if (advance) begin
				valid_s1 <= 1'b0;
			end
			if (advance) begin
				valid_s2 <= 1'b1;
				state_q  <= state_next;
			end else if (!res_stall) begin
				valid_s2 <= 1'b0;
			end
		end
	end

	// Payload registers carry no reset.
	always_ff @(posedge clk) begin
		if (req_take) begin
			cmd_s1  <= cmd;
			time_s1 <= time_req;
		end
		if (advance) begin
			res_s2 <= res_next;
		end
	end

	assign res_valid        = valid_s2;
	assign gap_closed       = res_s2.gap_closed;
	assign gap_value        = res_s2.gap_value;
	assign gap_total        = res_s2.gap_total;
	assign gap_min          = res_s2.gap_min;
	assign gap_max          = res_s2.gap_max;
	assign gap_count        = res_s2.gap_count;
	assign pending_requests = res_s2.pending_requests;

endmodule

### tb/testbench.sv
// Self-checking testbench for the idle gap statistics core.
module testbench;
	timeunit 1ns;
	timeprecision 1ps;

	import igs_pkg::*;

	localparam logic [1:0] CMD_UNDEFINED  = 2'd3;
	localparam int         WATCHDOG_LIMIT = 2000;
	localparam int         HOLD_CYCLES    = 150;
	localparam int         RANDOM_PER_MODE = 175;
	localparam int         BURST_LEN      = 20;
	localparam logic [63:0] ALL_ONES      = '1;

	typedef enum logic [1:0] {
		NO_IDLE,
		SEND_IDLE,
		RECV_STALL,
		BOTH_IDLE
	} idle_mode_t;

	typedef struct {
		logic [1:0]  cmd;
		logic [63:0] stamp;
		idle_mode_t  mode;
		logic        drain_first;
		logic        hold_start;
	} event_item_t;

	logic        clk       = 1'b0;
	logic        arst_n    = 1'b0;
	logic        req_valid = 1'b0;
	logic        req_stall;
	logic [1:0]  cmd       = CMD_ISSUE;
	logic [63:0] time_req  = '0;
	logic        res_valid;
	logic        res_stall = 1'b0;
	logic        gap_closed;
	logic [63:0] gap_value;
	logic [63:0] gap_total;
	logic [63:0] gap_min;
	logic [63:0] gap_max;
	logic [31:0] gap_count;
	logic [15:0] pending_requests;

	event_item_t   event_queue[$];
	stats_result_t expected_stats[$];

	// Predictor state, mirrors the statistics kept by the block.
	logic [PENDING_WIDTH-1:0] outstanding;
	logic [63:0]              last_done_time;
	logic                     last_done_seen;
	logic [63:0]              open_gap;
	logic                     open_gap_live;
	logic [63:0]              gap_sum;
	logic [63:0]              gap_lo;
	logic [63:0]              gap_hi;
	logic [31:0]              gap_num;

	idle_mode_t  mode_now    = NO_IDLE;
	int          hold_seq    = 0;
	int          hold_seen   = 0;
	int          hold_left   = 0;
	int          fail_count  = 0;
	int          stuck_cycles = 0;
	logic [63:0] trace_now   = '0;

	idle_gap_statistics_core dut (
		.clk              (clk),
		.arst_n           (arst_n),
		.req_valid        (req_valid),
		.req_stall        (req_stall),
		.cmd              (cmd),
		.time_req         (time_req),
		.res_valid        (res_valid),
		.res_stall        (res_stall),
		.gap_closed       (gap_closed),
		.gap_value        (gap_value),
		.gap_total        (gap_total),
		.gap_min          (gap_min),
		.gap_max          (gap_max),
		.gap_count        (gap_count),
		.pending_requests (pending_requests)
	);

	function automatic stats_result_t step_stats(logic [1:0] c, logic [63:0] t);
		stats_result_t r;
		r.gap_closed = 1'b0;
		r.gap_value  = '0;
		case (c)
			CMD_ISSUE: begin
				if (outstanding == '0 && last_done_seen) begin
					open_gap      = t - last_done_time;
					open_gap_live = 1'b1;
				end
				if (outstanding != '1)
					outstanding = outstanding + 1'b1;
			end
			CMD_COMPLETE: begin
				if (outstanding != '0) begin
					outstanding = outstanding - 1'b1;
					if (outstanding == '0) begin
						last_done_time = t;
						last_done_seen = 1'b1;
						if (open_gap_live) begin
							r.gap_closed  = 1'b1;
							r.gap_value   = open_gap;
							gap_sum       = gap_sum + open_gap;
							if (open_gap < gap_lo)
								gap_lo = open_gap;
							if (open_gap > gap_hi)
								gap_hi = open_gap;
							gap_num       = gap_num + 1'b1;
							open_gap_live = 1'b0;
						end
					end
				end
			end
			CMD_REQUEUE: begin
				if (outstanding != '0) begin
					outstanding = outstanding - 1'b1;
					if (outstanding == '0)
						open_gap_live = 1'b0;
				end
			end
			default: ;
		endcase
		r.gap_total        = gap_sum;
		r.gap_min          = gap_lo;
		r.gap_max          = gap_hi;
		r.gap_count        = gap_num;
		r.pending_requests = 16'(outstanding);
		return r;
	endfunction

	task automatic add_event(logic [1:0] c, logic [63:0] t, idle_mode_t m,
			logic drain = 1'b0, logic hold = 1'b0);
		event_item_t it;
		it.cmd         = c;
		it.stamp       = t;
		it.mode        = m;
		it.drain_first = drain;
		it.hold_start  = hold;
		event_queue.push_back(it);
	endtask

	// Mostly small forward steps; now and then a jump anywhere in the 64-bit range.
	function automatic logic [63:0] advance_trace();
		if ($urandom_range(19) == 0)
			trace_now = {$urandom, $urandom};
		else
			trace_now = trace_now + $urandom_range(1, 5000);
		return trace_now;
	endfunction

	// Bursts of issues drained by completions, with requeues and stray events mixed in.
	task automatic add_traffic(idle_mode_t m, int n);
		int   target;
		int   remaining;
		int   extras;
		logic first;
		target = event_queue.size() + n;
		first  = 1'b1;
		while (event_queue.size() < target) begin
			if ($urandom_range(9) == 0) begin
				add_event(2'($urandom_range(3)), {$urandom, $urandom}, m, first);
				first = 1'b0;
			end else begin
				remaining = ($urandom_range(7) == 0) ? $urandom_range(1, 8) : $urandom_range(1, 3);
				extras    = 0;
				for (int i = 0; i < remaining; i++) begin
					add_event(CMD_ISSUE, advance_trace(), m, first);
					first = 1'b0;
				end
				while (remaining > 0) begin
					if (extras < 3 && $urandom_range(7) == 0) begin
						add_event(CMD_ISSUE, advance_trace(), m);
						remaining++;
						extras++;
					end else begin
						add_event(($urandom_range(9) == 0) ? CMD_REQUEUE : CMD_COMPLETE,
							advance_trace(), m);
						remaining--;
					end
				end
			end
		end
	endtask

	initial begin
		forever #5 clk = ~clk;
	end

	always @(posedge clk or negedge arst_n) begin
		event_item_t nxt;
		logic        busy;
		logic        launch;
		int          gap_pct;
		if (!arst_n) begin
			req_valid      <= 1'b0;
			outstanding    = '0;
			last_done_time = '0;
			last_done_seen = 1'b0;
			open_gap       = '0;
			open_gap_live  = 1'b0;
			gap_sum        = '0;
			gap_lo         = ALL_ONES;
			gap_hi         = '0;
			gap_num        = '0;
		end else begin
			busy   = req_valid;
			launch = 1'b0;
			if (req_valid && !req_stall) begin
				expected_stats.push_back(step_stats(cmd, time_req));
				busy = 1'b0;
			end
			if (!busy && event_queue.size() > 0) begin
				nxt = event_queue[0];
				case (nxt.mode)
					SEND_IDLE: gap_pct = 61;
					BOTH_IDLE: gap_pct = 9;
					default:   gap_pct = 0;
				endcase
				if (!(nxt.drain_first && expected_stats.size() > 0)
						&& $urandom_range(99) >= gap_pct) begin
					launch   = 1'b1;
					cmd      <= nxt.cmd;
					time_req <= nxt.stamp;
					mode_now = nxt.mode;
					if (nxt.hold_start)
						hold_seq++;
					void'(event_queue.pop_front());
				end
			end
			req_valid <= busy || launch;
		end
	end

	always @(posedge clk or negedge arst_n) begin
		stats_result_t got;
		stats_result_t want;
		logic          stall_next;
		int            stall_pct;
		if (!arst_n) begin
			res_stall <= 1'b0;
		end else begin
			if (res_valid && !res_stall) begin
				got = '{gap_closed, gap_value, gap_total, gap_min, gap_max, gap_count,
					pending_requests};
				if (expected_stats.size() == 0) begin
					fail_count++;
					if (fail_count <= 10)
						$display("unexpected result transfer: closed=%0b value=%h count=%0d",
							got.gap_closed, got.gap_value, got.gap_count);
				end else begin
					want = expected_stats.pop_front();
					if (got !== want) begin
						fail_count++;
						if (fail_count <= 10) begin
							$display("mismatch expected: closed=%0b value=%h total=%h min=%h max=%h count=%h pend=%h",
								want.gap_closed, want.gap_value, want.gap_total, want.gap_min,
								want.gap_max, want.gap_count, want.pending_requests);
							$display("mismatch actual:   closed=%0b value=%h total=%h min=%h max=%h count=%h pend=%h",
								got.gap_closed, got.gap_value, got.gap_total, got.gap_min,
								got.gap_max, got.gap_count, got.pending_requests);
						end
					end
				end
			end
			// A long hold-off lets the block fill up and push back on the sender.
			if (hold_seen != hold_seq) begin
				hold_seen = hold_seq;
				hold_left = HOLD_CYCLES;
			end
			case (mode_now)
				RECV_STALL: stall_pct = 61;
				BOTH_IDLE:  stall_pct = 9;
				default:    stall_pct = 0;
			endcase
			if (hold_left > 0) begin
				hold_left--;
				stall_next = 1'b1;
			end else begin
				stall_next = ($urandom_range(99) < stall_pct);
			end
			res_stall <= stall_next;
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if ((req_valid && !req_stall) || (res_valid && !res_stall))
				stuck_cycles = 0;
			else
				stuck_cycles++;
			if (stuck_cycles >= WATCHDOG_LIMIT) begin
				$display("status: fail");
				$finish;
			end
		end
	end

	initial begin
		// Directed sequence: empty-device events, first issue, wrapping gaps, discards.
		add_event(CMD_COMPLETE,  64'd5,    NO_IDLE);
		add_event(CMD_REQUEUE,   64'd6,    NO_IDLE);
		add_event(CMD_UNDEFINED, 64'd7,    NO_IDLE);
		add_event(CMD_ISSUE,     64'd10,   NO_IDLE);
		add_event(CMD_ISSUE,     64'd20,   NO_IDLE);
		add_event(CMD_COMPLETE,  64'd30,   NO_IDLE);
		add_event(CMD_COMPLETE,  64'd40,   NO_IDLE);
		add_event(CMD_ISSUE,     64'd100,  NO_IDLE);
		add_event(CMD_COMPLETE,  64'd150,  NO_IDLE);
		add_event(CMD_ISSUE,     64'd150,  NO_IDLE);
		add_event(CMD_COMPLETE,  64'd151,  NO_IDLE);
		add_event(CMD_ISSUE,     64'd0,    NO_IDLE);
		add_event(CMD_COMPLETE,  ALL_ONES, NO_IDLE);
		add_event(CMD_ISSUE,     64'd5,    NO_IDLE);
		add_event(CMD_REQUEUE,   64'd9,    NO_IDLE);
		add_event(CMD_COMPLETE,  64'd9,    NO_IDLE);
		add_event(CMD_ISSUE,     64'd20,   NO_IDLE);
		add_event(CMD_ISSUE,     64'd25,   NO_IDLE);
		add_event(CMD_REQUEUE,   64'd26,   NO_IDLE);
		add_event(CMD_COMPLETE,  64'd30,   NO_IDLE);
		add_event(CMD_UNDEFINED, ALL_ONES, NO_IDLE);
		add_event(CMD_ISSUE,     64'd0,    NO_IDLE);
		add_event(CMD_REQUEUE,   64'd0,    NO_IDLE);
		add_event(CMD_ISSUE,     ALL_ONES, NO_IDLE);
		add_event(CMD_COMPLETE,  64'd0,    NO_IDLE);

		add_traffic(NO_IDLE,    RANDOM_PER_MODE);
		add_traffic(SEND_IDLE,  RANDOM_PER_MODE);
		add_traffic(RECV_STALL, RANDOM_PER_MODE);
		add_traffic(BOTH_IDLE,  RANDOM_PER_MODE);

		// Wait for every result, then hold the receiver off while a burst keeps coming.
		add_event(CMD_ISSUE, advance_trace(), NO_IDLE, 1'b1, 1'b1);
		for (int i = 0; i < BURST_LEN; i++)
			add_event(CMD_ISSUE, advance_trace(), NO_IDLE);
		for (int i = 0; i < BURST_LEN + 1; i++)
			add_event(CMD_COMPLETE, advance_trace(), NO_IDLE);

		add_traffic(BOTH_IDLE, 60);

		repeat (9) @(posedge clk);
		arst_n <= 1'b1;

		while (event_queue.size() > 0 || req_valid || expected_stats.size() > 0)
			@(posedge clk);
		repeat (8) @(posedge clk);
		if (fail_count == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

endmodule

### sim.f
rtl/igs_pkg.sv
rtl/igs_update.sv
rtl/idle_gap_statistics_core.sv
tb/testbench.sv
